>>> design/mlpbp_pkg.sv
// ----------------------------------------------------------------------------
// mlpbp_pkg
// shared types and constants of the two-layer perceptron training engine
// ----------------------------------------------------------------------------
package mlpbp_pkg;

   localparam int DEF_N_HID     = 2;
   localparam int DEF_SIG_DEPTH = 1024;

   localparam logic [1:0]  OP_LOAD  = 2'd0;
   localparam logic [1:0]  OP_INFER = 2'd1;
   localparam logic [1:0]  OP_TRAIN = 2'd2;

   localparam logic [15:0] LEARN_RATE_RESET = 16'd1792;
   localparam logic [17:0] Q_ONE            = 18'd65536;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [16:0]        x_first;
      logic [16:0]        x_second;
      logic [16:0]        target_value;
      logic [4:0]         param_index;
      logic signed [31:0] param_value;
   } req_word_type;

   typedef struct packed {
      logic [16:0] net_output;
      logic [15:0] half_sq_error;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HMAC, ST_OBIAS, ST_OMAC, ST_SIG, ST_ERR, ST_GO, ST_SO,
      ST_SO2, ST_GH, ST_T1, ST_SH, ST_SH2, ST_UPD, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      TGT_HW0, TGT_HW1, TGT_HB, TGT_OW, TGT_OB
   } tgt_type;

   typedef enum logic [1:0] {
      MAC_HOLD, MAC_LOAD, MAC_ADD, MAC_SHADD
   } mac_type;

endpackage

>>> design/mlpbp_stream_if.sv
// ----------------------------------------------------------------------------
// mlpbp_stream_if
// valid/ready channel carrying one word per handshake
// ----------------------------------------------------------------------------
interface mlpbp_stream_if #(parameter type word_type = logic) ();

   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);

endinterface

>>> design/mlp_backprop_train_step.sv
// Two-input, N_HID-hidden-node sigmoid perceptron that holds its own weights and
// learns online. A load word writes one weight or bias as it is accepted; infer
// and train words are sequenced through the single shared 35x18
// multiply-accumulate unit that steps through every product of the forward pass,
// the deltas and the updates, and each sigmoid takes the index product, then the
// table address and the registered table read. The input is not ready while a word
// is in progress; a finished result waits in the output register while the next
// word is taken.
// ----------------------------------------------------------------------------
// mlp_backprop_train_step
// forward pass and online backpropagation over a shared multiply-accumulate
// ----------------------------------------------------------------------------
module mlp_backprop_train_step #(
   parameter int N_HID           = mlpbp_pkg::DEF_N_HID,
   parameter int SIG_TABLE_DEPTH = mlpbp_pkg::DEF_SIG_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   mlpbp_stream_if.sink          req_chan,
   mlpbp_stream_if.source        rsp_chan
);

   import mlpbp_pkg::*;

   localparam int NODE_W = (N_HID > 1) ? $clog2(N_HID) : 1;
   localparam int HW_AW  = $clog2(2 * N_HID);
   localparam int IDX_W  = $clog2(SIG_TABLE_DEPTH);
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(N_HID - 1);
   localparam logic [63:0] ONE30 = 64'd1 << 30;

   typedef logic [16:0] rom_type [SIG_TABLE_DEPTH];

   // quotient by trial multiplication
   function automatic logic [63:0] udiv_search(input logic [63:0] num,
                                               input logic [63:0] den,
                                               input int bits);
      logic [63:0]  q;
      logic [63:0]  trial;
      logic [127:0] prod;
      q = '0;
      for (int b = bits - 1; b >= 0; b--) begin
         trial = q | (64'd1 << b);
         prod  = 128'(trial) * 128'(den);
         if (prod <= 128'(num)) q = trial;
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_frac(input logic [63:0] f);
      logic [63:0]        term;
      logic signed [63:0] sum;
      term = ONE30;
      sum  = $signed(ONE30);
      for (int k = 1; k <= 16; k++) begin
         term = udiv_search((term * f) >> 30, 64'(k), 31);
         if (k[0]) sum = sum - $signed(term);
         else      sum = sum + $signed(term);
      end
      return (sum < 0) ? 64'd0 : $unsigned(sum);
   endfunction

   function automatic rom_type build_rom();
      rom_type            rom;
      logic [63:0]        e1;
      logic [63:0]        t;
      logic [63:0]        n;
      logic [63:0]        p;
      logic [63:0]        den;
      logic [63:0]        s;
      logic signed [63:0] x;
      e1 = exp_frac(ONE30);
      for (int i = 0; i < SIG_TABLE_DEPTH; i++) begin
         x   = $signed((64'(2 * i + 1) * 64'd8 * ONE30) / SIG_TABLE_DEPTH)
               - $signed(64'd8 * ONE30);
         t   = (x < 0) ? $unsigned(-x) : $unsigned(x);
         n   = t >> 30;
         p   = exp_frac(t & (ONE30 - 64'd1));
         for (int k = 0; 64'(k) < n; k++) p = (p * e1) >> 30;
         den = ONE30 + p;
         s   = udiv_search((64'd1 << 46) + (den >> 1), den, 18);
         rom[i] = (x < 0) ? 17'(64'd65536 - s) : 17'(s);
      end
      return rom;
   endfunction

   localparam rom_type SIG_ROM = build_rom();

   // control
   state_type          state_ff, state_in;
   tgt_type            tgt_ff, tgt_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic               out_pass_ff, out_pass_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_ready;

   // parameters
   logic signed [31:0] hw_ff [2*N_HID];
   logic signed [31:0] hw_in [2*N_HID];
   logic signed [31:0] hb_ff [N_HID];
   logic signed [31:0] hb_in [N_HID];
   logic signed [31:0] ow_ff [N_HID];
   logic signed [31:0] ow_in [N_HID];
   logic signed [31:0] ob_ff, ob_in;
   logic [15:0]        lr_ff, lr_in;

   // working registers
   logic [1:0]         op_ff, op_in;
   logic [16:0]        x0_ff, x0_in, x1_ff, x1_in, t_ff, t_in;
   logic [16:0]        h_ff [N_HID];
   logic [16:0]        h_in [N_HID];
   logic [16:0]        y_ff, y_in;
   logic signed [17:0] e_ff, e_in;
   logic [15:0]        hse_ff, hse_in;
   logic signed [16:0] so_ff, so_in;
   logic [14:0]        gh_ff, gh_in;
   logic signed [29:0] sig_ff, sig_in;
   logic [16:0]        alo_ff, alo_in;
   logic [16:0]        plo_ff, plo_in;
   logic               clamp_lo_ff, clamp_lo_in, clamp_hi_ff, clamp_hi_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [16:0]        rom_q_ff;
   logic [IDX_W-1:0]   rom_addr;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   // shared multiply-accumulate
   logic signed [34:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [52:0] mul_p;
   mac_type            mac_mode;

   // scratch
   logic signed [63:0] net;
   logic signed [17:0] err_val;
   logic signed [31:0] w_old;
   logic [17:0]        w_inp;
   logic signed [29:0] w_sig;
   logic signed [39:0] w_step;
   logic signed [40:0] w_diff;
   logic signed [31:0] w_new;
   logic [5:0]         pidx;
   logic [HW_AW-1:0]   hw_a0, hw_a1;

   assign mul_p = mul_a * mul_b;

   always_comb begin
      case (mac_mode)
         MAC_LOAD:  acc_in = 64'(mul_p);
         MAC_ADD:   acc_in = acc_ff + 64'(mul_p);
         MAC_SHADD: acc_in = (acc_ff <<< 17) + 64'(mul_p);
         default:   acc_in = acc_ff;
      endcase
   end

   assign hw_a0   = HW_AW'({node_ff, 1'b0});
   assign hw_a1   = HW_AW'({node_ff, 1'b1});
   assign err_val = $signed({1'b0, y_ff}) - $signed({1'b0, t_ff});
   assign pidx    = {1'b0, req_chan.word.param_index};

   // update operands
   always_comb begin
      case (tgt_ff)
         TGT_HW0: begin
            w_old = hw_ff[hw_a0]; w_inp = 18'(x0_ff); w_sig = sig_ff;
         end
         TGT_HW1: begin
            w_old = hw_ff[hw_a1]; w_inp = 18'(x1_ff); w_sig = sig_ff;
         end
         TGT_HB: begin
            w_old = hb_ff[node_ff]; w_inp = Q_ONE; w_sig = sig_ff;
         end
         TGT_OW: begin
            w_old = ow_ff[node_ff]; w_inp = 18'(h_ff[node_ff]); w_sig = 30'(so_ff);
         end
         default: begin
            w_old = ob_ff; w_inp = Q_ONE; w_sig = 30'(so_ff);
         end
      endcase
      w_step = $signed(acc_ff[63:24]);
      w_diff = 41'(w_old) - 41'(w_step);
      if (!w_diff[40] && (|w_diff[39:31]))       w_new = 32'sh7FFF_FFFF;
      else if (w_diff[40] && !(&w_diff[39:31]))  w_new = 32'sh8000_0000;
      else                                       w_new = w_diff[31:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      tgt_in       = tgt_ff;
      cnt_in       = cnt_ff;
      node_in      = node_ff;
      out_pass_in  = out_pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      req_ready    = (state_ff == ST_IDLE);
      hw_in        = hw_ff;
      hb_in        = hb_ff;
      ow_in        = ow_ff;
      ob_in        = ob_ff;
      lr_in        = lr_ff;
      op_in        = op_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      t_in         = t_ff;
      h_in         = h_ff;
      y_in         = y_ff;
      e_in         = e_ff;
      hse_in       = hse_ff;
      so_in        = so_ff;
      gh_in        = gh_ff;
      sig_in       = sig_ff;
      alo_in       = alo_ff;
      plo_in       = plo_ff;
      clamp_lo_in  = clamp_lo_ff;
      clamp_hi_in  = clamp_hi_ff;
      rom_addr     = '0;
      mac_mode     = MAC_HOLD;
      mul_a        = '0;
      mul_b        = '0;
      net          = acc_ff + (64'sd1 <<< 35);

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in   = req_chan.word.opcode;
               x0_in   = req_chan.word.x_first;
               x1_in   = req_chan.word.x_second;
               t_in    = req_chan.word.target_value;
               node_in = '0;
               cnt_in  = '0;
               if (req_chan.word.opcode == OP_LOAD) begin
                  if (pidx < 6'(2 * N_HID))
                     hw_in[req_chan.word.param_index[HW_AW-1:0]] =
                        req_chan.word.param_value;
                  else if (pidx < 6'(3 * N_HID))
                     hb_in[NODE_W'(pidx - 6'(2 * N_HID))] = req_chan.word.param_value;
                  else if (pidx < 6'(4 * N_HID))
                     ow_in[NODE_W'(pidx - 6'(3 * N_HID))] = req_chan.word.param_value;
                  else if (pidx == 6'(4 * N_HID))
                     ob_in = req_chan.word.param_value;
                  state_in = ST_DONE;
               end else if (req_chan.word.opcode == OP_INFER ||
                            req_chan.word.opcode == OP_TRAIN) begin
                  out_pass_in = 1'b0;
                  state_in    = ST_HMAC;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_HMAC: begin
            case (cnt_ff)
               2'd0: begin
                  mul_a = 35'(hb_ff[node_ff]); mul_b = Q_ONE;
                  mac_mode = MAC_LOAD; cnt_in = 2'd1;
               end
               2'd1: begin
                  mul_a = 35'(hw_ff[hw_a0]); mul_b = 18'(x0_ff);
                  mac_mode = MAC_ADD; cnt_in = 2'd2;
               end
               default: begin
                  mul_a = 35'(hw_ff[hw_a1]); mul_b = 18'(x1_ff);
                  mac_mode = MAC_ADD; cnt_in = 2'd0; state_in = ST_SIG;
               end
            endcase
         end
         ST_OBIAS: begin
            mul_a = 35'(ob_ff); mul_b = Q_ONE; mac_mode = MAC_LOAD;
            node_in = '0; state_in = ST_OMAC;
         end
         ST_OMAC: begin
            mul_a = 35'(ow_ff[node_ff]); mul_b = 18'(h_ff[node_ff]);
            mac_mode = MAC_ADD;
            if (node_ff == LAST_NODE) begin
               out_pass_in = 1'b1; cnt_in = 2'd0; state_in = ST_SIG;
            end else begin
               node_in = node_ff + 1'b1;
            end
         end
         ST_SIG: begin
            case (cnt_ff)
               2'd0: begin
                  clamp_lo_in = net[63];
                  clamp_hi_in = !net[63] && (|net[62:36]);
                  alo_in      = net[16:0];
                  mul_a = 35'(net[35:17]); mul_b = 18'(SIG_TABLE_DEPTH);
                  mac_mode = MAC_LOAD; cnt_in = 2'd1;
               end
               2'd1: begin
                  mul_a = 35'(alo_ff); mul_b = 18'(SIG_TABLE_DEPTH);
                  mac_mode = MAC_SHADD; cnt_in = 2'd2;
               end
               2'd2: begin
                  if (clamp_lo_ff)      rom_addr = '0;
                  else if (clamp_hi_ff) rom_addr = IDX_W'(SIG_TABLE_DEPTH - 1);
                  else                  rom_addr = acc_ff[36 +: IDX_W];
                  cnt_in = 2'd3;
               end
               default: begin
                  cnt_in = 2'd0;
                  if (!out_pass_ff) begin
                     h_in[node_ff] = rom_q_ff;
                     if (node_ff == LAST_NODE) begin
                        state_in = ST_OBIAS;
                     end else begin
                        node_in  = node_ff + 1'b1;
                        state_in = ST_HMAC;
                     end
                  end else begin
                     y_in     = rom_q_ff;
                     state_in = (op_ff == OP_TRAIN) ? ST_ERR : ST_DONE;
                  end
               end
            endcase
         end
         ST_ERR: begin
            e_in = err_val;
            mul_a = 35'(err_val); mul_b = err_val; mac_mode = MAC_LOAD;
            state_in = ST_GO;
         end
         ST_GO: begin
            hse_in = acc_ff[33] ? 16'hFFFF : acc_ff[32:17];
            mul_a = 35'(y_ff); mul_b = Q_ONE - 18'(y_ff); mac_mode = MAC_LOAD;
            state_in = ST_SO;
         end
         ST_SO: begin
            mul_a = 35'(e_ff); mul_b = 18'(acc_ff[30:16]); mac_mode = MAC_LOAD;
            state_in = ST_SO2;
         end
         ST_SO2: begin
            so_in = $signed(acc_ff[32:16]); node_in = '0; state_in = ST_GH;
         end
         ST_GH: begin
            mul_a = 35'(h_ff[node_ff]); mul_b = Q_ONE - 18'(h_ff[node_ff]);
            mac_mode = MAC_LOAD; state_in = ST_T1;
         end
         ST_T1: begin
            gh_in = acc_ff[30:16];
            mul_a = 35'(ow_ff[node_ff]); mul_b = 18'(so_ff); mac_mode = MAC_LOAD;
            state_in = ST_SH;
         end
         ST_SH: begin
            mul_a = 35'($signed(acc_ff[47:16])); mul_b = 18'(gh_ff);
            mac_mode = MAC_LOAD; state_in = ST_SH2;
         end
         ST_SH2: begin
            sig_in = $signed(acc_ff[45:16]);
            tgt_in = TGT_HW0; cnt_in = 2'd0; state_in = ST_UPD;
         end
         ST_UPD: begin
            case (cnt_ff)
               2'd0: begin
                  mul_a = 35'(lr_ff); mul_b = w_inp; mac_mode = MAC_LOAD;
                  cnt_in = 2'd1;
               end
               2'd1: begin
                  plo_in = acc_ff[16:0];
                  mul_a = 35'(w_sig); mul_b = 18'(acc_ff[33:17]);
                  mac_mode = MAC_LOAD; cnt_in = 2'd2;
               end
               2'd2: begin
                  mul_a = 35'(w_sig); mul_b = 18'(plo_ff);
                  mac_mode = MAC_SHADD; cnt_in = 2'd3;
               end
               default: begin
                  cnt_in = 2'd0;
                  case (tgt_ff)
                     TGT_HW0: begin
                        hw_in[hw_a0] = w_new; tgt_in = TGT_HW1;
                     end
                     TGT_HW1: begin
                        hw_in[hw_a1] = w_new; tgt_in = TGT_HB;
                     end
                     TGT_HB: begin
                        hb_in[node_ff] = w_new; tgt_in = TGT_OW;
                     end
                     TGT_OW: begin
                        ow_in[node_ff] = w_new;
                        if (node_ff == LAST_NODE) begin
                           tgt_in = TGT_OB;
                        end else begin
                           node_in  = node_ff + 1'b1;
                           state_in = ST_GH;
                        end
                     end
                     default: begin
                        ob_in = w_new; state_in = ST_DONE;
                     end
                  endcase
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in.net_output =
                  (op_ff == OP_INFER || op_ff == OP_TRAIN) ? y_ff : '0;
               rsp_word_in.half_sq_error = (op_ff == OP_TRAIN) ? hse_ff : '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_wr_en) lr_in = csr_wr_data;
   end

   // control and parameter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tgt_ff       <= TGT_HW0;
         cnt_ff       <= '0;
         node_ff      <= '0;
         out_pass_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= LEARN_RATE_RESET;
         ob_ff        <= '0;
         for (int i = 0; i < 2 * N_HID; i++) hw_ff[i] <= '0;
         for (int i = 0; i < N_HID; i++) begin
            hb_ff[i] <= '0;
            ow_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tgt_ff       <= tgt_in;
         cnt_ff       <= cnt_in;
         node_ff      <= node_in;
         out_pass_ff  <= out_pass_in;
         rsp_valid_ff <= rsp_valid_in;
         lr_ff        <= lr_in;
         ob_ff        <= ob_in;
         hw_ff        <= hw_in;
         hb_ff        <= hb_in;
         ow_ff        <= ow_in;
      end
   end

   // working data
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      t_ff        <= t_in;
      h_ff        <= h_in;
      y_ff        <= y_in;
      e_ff        <= e_in;
      hse_ff      <= hse_in;
      so_ff       <= so_in;
      gh_ff       <= gh_in;
      sig_ff      <= sig_in;
      alo_ff      <= alo_in;
      plo_ff      <= plo_in;
      clamp_lo_ff <= clamp_lo_in;
      clamp_hi_ff <= clamp_hi_in;
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
   end

   // sigmoid table
   always_ff @(posedge clock) begin
      rom_q_ff <= SIG_ROM[rom_addr];
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_clamp_excl: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIG && cnt_ff != 2'd0) |-> !(clamp_lo_ff && clamp_hi_ff))
      else $error("sigmoid clamped both ways");

   a_node_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (node_ff <= LAST_NODE))
      else $error("node counter out of range");

   a_deriv_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SH) |-> (gh_ff <= 15'd16384))
      else $error("sigmoid derivative above a quarter");

   a_word_start: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready &&
       (req_chan.word.opcode == OP_INFER || req_chan.word.opcode == OP_TRAIN))
      |=> (state_ff == ST_HMAC && cnt_ff == 2'd0))
      else $error("forward pass did not start");
`endif

endmodule
